[rtl/csd_stitch_stream_decoder_macros.svh]
// assertion helpers for the decoder rtl (included by csd_ctrl)
`ifndef CSD_STITCH_STREAM_DECODER_MACROS_SVH
`define CSD_STITCH_STREAM_DECODER_MACROS_SVH

// cause in this cycle implies effect in the next
`define CSD_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("next-cycle check failed");

// condition implies consequence in the same cycle
`define CSD_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("same-cycle check failed");

`endif

[rtl/csd_pkg.sv]
package csd_pkg;

   localparam int SUB_MASK_SIZE = 479;
   localparam int XOR_MASK_SIZE = 501;
   localparam int ORDER_ENTRIES = 14;
   localparam int THREAD_COUNT  = 16;
   localparam int POSITION_BITS = 24;

   localparam int COLOUR_BYTES = THREAD_COUNT * 3;
   localparam int ORDER_START  = COLOUR_BYTES + 2;
   localparam int HEADER_BYTES = ORDER_START + ORDER_ENTRIES;
   localparam int FILL_STEPS   = SUB_MASK_SIZE + XOR_MASK_SIZE;

   localparam logic [31:0] LCG_MUL = 32'h41C64E6D;
   localparam logic [31:0] LCG_ADD = 32'h00003039;

   localparam logic [7:0] END_CODE_A = 8'hF8;
   localparam logic [7:0] END_CODE_B = 8'h87;
   localparam logic [7:0] END_CODE_C = 8'h91;
   localparam logic [4:0] FLAG_MASK   = 5'h1F;
   localparam logic [4:0] CHANGE_MASK = 5'h0C;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_SCRAMBLE_TYPE = 1'b0,
      CSR_KEY_SEED      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_COLOUR = 3'd0,
      KIND_NORMAL = 3'd1,
      KIND_TRIM   = 3'd2,
      KIND_CHANGE = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DECODE
   } state_type;

   typedef struct packed {
      logic start_load;
      logic fill_en;
      logic read_en;
      logic decode_en;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic out_free;
      logic done;
   } status_type;

   localparam logic [7:0] PERM_TABLE [256] = '{
      8'h43,8'h6E,8'h72,8'h7A,8'h76,8'h6C,8'h61,8'h6F,8'h7C,8'h29,8'h5D,8'h62,8'h60,8'h6E,8'h61,8'h62,
      8'h20,8'h41,8'h66,8'h6A,8'h3A,8'h35,8'h5A,8'h63,8'h7C,8'h37,8'h3A,8'h2A,8'h25,8'h24,8'h2A,8'h33,
      8'h00,8'h10,8'h14,8'h03,8'h72,8'h4C,8'h48,8'h42,8'h08,8'h7A,8'h5E,8'h0B,8'h6F,8'h45,8'h47,8'h5F,
      8'h40,8'h54,8'h5C,8'h57,8'h55,8'h59,8'h53,8'h3A,8'h32,8'h6F,8'h53,8'h54,8'h50,8'h5C,8'h4A,8'h56,
      8'h2F,8'h2F,8'h62,8'h2C,8'h22,8'h65,8'h25,8'h28,8'h38,8'h30,8'h38,8'h22,8'h2B,8'h25,8'h3A,8'h6F,
      8'h27,8'h38,8'h3E,8'h3F,8'h74,8'h37,8'h33,8'h77,8'h2E,8'h30,8'h3D,8'h34,8'h2E,8'h32,8'h2B,8'h2C,
      8'h0C,8'h18,8'h42,8'h13,8'h16,8'h0A,8'h15,8'h02,8'h0B,8'h1C,8'h1E,8'h0E,8'h08,8'h60,8'h64,8'h0D,
      8'h09,8'h51,8'h25,8'h1A,8'h18,8'h16,8'h19,8'h1A,8'h58,8'h10,8'h14,8'h5B,8'h08,8'h15,8'h1B,8'h5F,
      8'hD5,8'hD2,8'hAE,8'hA3,8'hC1,8'hF0,8'hF4,8'hE8,8'hF8,8'hEC,8'hA6,8'hAB,8'hCD,8'hF8,8'hFD,8'hFB,
      8'hE2,8'hF0,8'hFE,8'hFA,8'hF5,8'hB5,8'hF7,8'hF9,8'hFC,8'hB9,8'hF5,8'hEF,8'hF4,8'hF8,8'hEC,8'hBF,
      8'hC3,8'hCE,8'hD7,8'hCD,8'hD0,8'hD7,8'hCF,8'hC2,8'hDB,8'hA4,8'hA0,8'hB0,8'hAF,8'hBE,8'h98,8'hE2,
      8'hC2,8'h91,8'hE5,8'hDC,8'hDA,8'hD2,8'h96,8'hC4,8'h98,8'hF8,8'hC9,8'hD2,8'hDD,8'hD3,8'h9E,8'hDE,
      8'hAE,8'hA5,8'hE2,8'h8C,8'hB6,8'hAC,8'hA3,8'hA9,8'hBC,8'hA8,8'hA6,8'hEB,8'h8B,8'hBF,8'hA1,8'hAC,
      8'hB5,8'hA3,8'hBB,8'hB6,8'hA7,8'hD8,8'hDC,8'h9A,8'hAA,8'hF9,8'h82,8'hFB,8'h9D,8'hB9,8'hAB,8'hB3,
      8'h94,8'hC1,8'hA0,8'h8C,8'h8B,8'h8E,8'h95,8'h8F,8'h87,8'h99,8'hE7,8'hE1,8'hA3,8'h83,8'h8B,8'hCF,
      8'hA3,8'h85,8'h9D,8'h83,8'hD4,8'hB7,8'h83,8'h84,8'h91,8'h97,8'h9F,8'h88,8'h8F,8'hDD,8'hAD,8'h90
   };

endpackage

[rtl/csd_if.sv]
interface csd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] raw_byte;

   modport source (output valid, output req_type, output raw_byte, input ready);
   modport sink (input valid, input req_type, input raw_byte, output ready);
endinterface

interface csd_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic [3:0]        thread_index;
   logic [7:0]        red;
   logic [7:0]        green;
   logic [7:0]        blue;
   logic signed [7:0] delta_x;
   logic signed [7:0] delta_y;
   logic [7:0]        order_colour;
   logic              bad_change;

   modport source (output valid, output kind, output thread_index, output red,
                   output green, output blue, output delta_x, output delta_y,
                   output order_colour, output bad_change, input ready);
   modport sink (input valid, input kind, input thread_index, input red,
                 input green, input blue, input delta_x, input delta_y,
                 input order_colour, input bad_change, output ready);
endinterface

interface csd_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/csd_stitch_stream_decoder.sv]
// channel  | port     | direction | carries
// request  | req_bus  | in        | req_type (start or data byte), raw_byte
// result   | rsp_bus  | out       | kind, thread, colour, deltas, order colour, flag
// config   | csr_bus  | in        | index (0 scramble type, 1 key seed), data
//
// a data request: mask read at accept, then decode and result register
// a start request: one lcg step per cycle fills the 980 mask bytes
// reset (synchronous, high) clears parser, config and result valid; masks stay unwritten
// a full result register holds the decode step until the result is taken
// data requests after the end marker are taken and dropped until the next start
module csd_stitch_stream_decoder (
   input logic        clock,
   input logic        reset,
   csd_req_if.sink    req_bus,
   csd_rsp_if.source  rsp_bus,
   csd_csr_if.sink    csr_bus
);

   csd_pkg::cmd_type    cmd;
   csd_pkg::status_type status;

   // sequencer: start fill, data read, decode
   csd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // masks, position tracking, stitch parser and result register
   csd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .raw_byte (req_bus.raw_byte),
      .csr      (csr_bus),
      .rsp      (rsp_bus)
   );

endmodule

[rtl/csd_ctrl.sv]
`include "csd_stitch_stream_decoder_macros.svh"

module csd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   output csd_pkg::cmd_type    cmd,
   input  csd_pkg::status_type status
);

   csd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         csd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == csd_pkg::REQ_START) begin
                  cmd.start_load = 1'b1;
                  state_in       = csd_pkg::ST_FILL;
               end else if (!status.done) begin
                  cmd.read_en = 1'b1;
                  state_in    = csd_pkg::ST_DECODE;
               end
            end
         end
         csd_pkg::ST_FILL: begin
            cmd.fill_en = 1'b1;
            if (status.fill_last) begin
               state_in = csd_pkg::ST_IDLE;
            end
         end
         csd_pkg::ST_DECODE: begin
            if (status.out_free) begin
               cmd.decode_en = 1'b1;
               state_in      = csd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csd_pkg::ST_IDLE;
         end
      endcase
   end

   `CSD_ASSERT_NEXT(a_start_fills, clock, reset, cmd.start_load, state_ff == csd_pkg::ST_FILL)
   `CSD_ASSERT_NEXT(a_fill_ends, clock, reset, cmd.fill_en && status.fill_last, state_ff == csd_pkg::ST_IDLE)
   `CSD_ASSERT_NEXT(a_decode_waits, clock, reset, state_ff == csd_pkg::ST_DECODE && !status.out_free, state_ff == csd_pkg::ST_DECODE)
   `CSD_ASSERT_NOW(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))

endmodule

[rtl/csd_datapath.sv]
module csd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  csd_pkg::cmd_type    cmd,
   output csd_pkg::status_type status,
   input  logic [7:0]          raw_byte,
   csd_csr_if.sink             csr,
   csd_rsp_if.source           rsp
);

   localparam int PB = csd_pkg::POSITION_BITS;

   // configuration
   logic       scramble_ff;
   logic [7:0] seed_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scramble_ff <= 1'b0;
         seed_ff     <= 8'd12;
      end else if (csr.valid) begin
         unique case (csr.index)
            csd_pkg::CSR_SCRAMBLE_TYPE: scramble_ff <= csr.data[0];
            csd_pkg::CSR_KEY_SEED:      seed_ff     <= csr.data;
            default:                    scramble_ff <= scramble_ff;
         endcase
      end
   end

   // mask generator
   logic [31:0] lcg_ff, lcg_in;
   logic [9:0]  fill_cnt_ff;
   logic [9:0]  xor_fill_addr;
   logic [7:0]  sub_mem [csd_pkg::SUB_MASK_SIZE];
   logic [7:0]  xor_mem [csd_pkg::XOR_MASK_SIZE];

   assign lcg_in        = lcg_ff * csd_pkg::LCG_MUL + csd_pkg::LCG_ADD;
   assign xor_fill_addr = fill_cnt_ff - 10'(csd_pkg::SUB_MASK_SIZE);

   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         lcg_ff      <= {24'd0, seed_ff};
         fill_cnt_ff <= '0;
      end else if (cmd.fill_en) begin
         lcg_ff      <= lcg_in;
         fill_cnt_ff <= fill_cnt_ff + 10'd1;
      end
   end

   assign status.fill_last = fill_cnt_ff == 10'(csd_pkg::FILL_STEPS - 1);

   // position and running remainders of its high part
   logic [PB-1:0] pos_ff;
   logic [8:0]    hm_sub_ff, hp_sub_ff, hm_xor_ff, hp_xor_ff;
   logic [1:0]    hi3_ff;
   logic [7:0]    low, off;
   logic          adjust;
   logic [8:0]    base_sub, base_xor;
   logic [9:0]    sum_sub, sum_xor, step_sub, step_xor;
   logic [8:0]    sub_addr, xor_addr;

   assign low    = pos_ff[7:0];
   assign adjust = scramble_ff && ((hi3_ff == 2'd2 && low == 8'd0) ||
                                   (hi3_ff == 2'd1 && low <= 8'd1));
   assign off      = scramble_ff ? csd_pkg::PERM_TABLE[low] : low;
   assign base_sub = adjust ? hp_sub_ff : hm_sub_ff;
   assign base_xor = adjust ? hp_xor_ff : hm_xor_ff;
   assign sum_sub  = {1'b0, base_sub} + {2'b0, off};
   assign sum_xor  = {1'b0, base_xor} + {2'b0, off};
   assign sub_addr = (sum_sub >= 10'(csd_pkg::SUB_MASK_SIZE)) ?
                     9'(sum_sub - 10'(csd_pkg::SUB_MASK_SIZE)) : sum_sub[8:0];
   assign xor_addr = (sum_xor >= 10'(csd_pkg::XOR_MASK_SIZE)) ?
                     9'(sum_xor - 10'(csd_pkg::XOR_MASK_SIZE)) : sum_xor[8:0];
   assign step_sub = {1'b0, hm_sub_ff} + 10'd256;
   assign step_xor = {1'b0, hm_xor_ff} + 10'd256;

   // masks
   logic [7:0] sub_rd_ff, xor_rd_ff, raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.fill_en) begin
         if (fill_cnt_ff < 10'(csd_pkg::SUB_MASK_SIZE)) begin
            sub_mem[fill_cnt_ff[8:0]] <= lcg_in[23:16];
         end else begin
            xor_mem[xor_fill_addr[8:0]] <= lcg_in[23:16];
         end
      end
      if (cmd.read_en) begin
         sub_rd_ff <= sub_mem[sub_addr];
         xor_rd_ff <= xor_mem[xor_addr];
         raw_ff    <= raw_byte;
      end
   end

   // parser
   logic [6:0]  hdr_ff;
   logic [1:0]  phase_ff;
   logic [3:0]  thread_ff;
   logic [7:0]  held0_ff, held1_ff;
   logic [7:0]  order_ff [csd_pkg::ORDER_ENTRIES];
   logic [4:0]  cc_ff;
   logic        done_ff;
   logic [7:0]  d;
   logic [6:0]  order_pos;
   logic [4:0]  cc_dec, order_idx;
   logic [4:0]  flags;
   logic        is_end;

   assign d         = (raw_ff ^ xor_rd_ff) - sub_rd_ff;
   assign order_pos = hdr_ff - 7'(csd_pkg::ORDER_START);
   assign cc_dec    = cc_ff - 5'd1;
   assign flags     = held0_ff[4:0] & csd_pkg::FLAG_MASK;
   assign is_end    = held0_ff == csd_pkg::END_CODE_A || held0_ff == csd_pkg::END_CODE_B ||
                      held0_ff == csd_pkg::END_CODE_C;

   always_comb begin
      if (cc_ff == 5'd0) begin
         order_idx = 5'd0;
      end else if (cc_dec >= 5'(2 * csd_pkg::ORDER_ENTRIES)) begin
         order_idx = cc_dec - 5'(2 * csd_pkg::ORDER_ENTRIES);
      end else if (cc_dec >= 5'(csd_pkg::ORDER_ENTRIES)) begin
         order_idx = cc_dec - 5'(csd_pkg::ORDER_ENTRIES);
      end else begin
         order_idx = cc_dec;
      end
   end

   assign status.done     = done_ff;
   assign status.out_free = !rsp.valid || rsp.ready;

   // result register
   logic              rsp_valid_ff;
   csd_pkg::kind_type kind_ff;
   logic [3:0]        thread_out_ff;
   logic [7:0]        red_ff, green_ff, blue_ff, order_out_ff;
   logic [7:0]        dx_ff, dy_ff;
   logic              bad_ff;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.thread_index = thread_out_ff;
   assign rsp.red          = red_ff;
   assign rsp.green        = green_ff;
   assign rsp.blue         = blue_ff;
   assign rsp.delta_x      = dx_ff;
   assign rsp.delta_y      = dy_ff;
   assign rsp.order_colour = order_out_ff;
   assign rsp.bad_change   = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= PB'(8);
         hm_sub_ff    <= '0;
         hp_sub_ff    <= '0;
         hm_xor_ff    <= '0;
         hp_xor_ff    <= '0;
         hi3_ff       <= '0;
         hdr_ff       <= '0;
         phase_ff     <= '0;
         thread_ff    <= '0;
         held0_ff     <= '0;
         held1_ff     <= '0;
         cc_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.start_load) begin
         // a waiting result may still be taken while the start is accepted
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         pos_ff    <= PB'(8);
         hm_sub_ff <= '0;
         hp_sub_ff <= '0;
         hm_xor_ff <= '0;
         hp_xor_ff <= '0;
         hi3_ff    <= '0;
         hdr_ff    <= '0;
         phase_ff  <= '0;
         thread_ff <= '0;
         held0_ff  <= '0;
         held1_ff  <= '0;
         cc_ff     <= '0;
         done_ff   <= 1'b0;
      end else begin
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.decode_en) begin
            pos_ff <= pos_ff + PB'(1);
            if (low == 8'hFF) begin
               if (&pos_ff[PB-1:8]) begin
                  hm_sub_ff <= '0;
                  hm_xor_ff <= '0;
                  hi3_ff    <= '0;
               end else begin
                  hp_sub_ff <= hm_sub_ff;
                  hp_xor_ff <= hm_xor_ff;
                  hm_sub_ff <= (step_sub >= 10'(csd_pkg::SUB_MASK_SIZE)) ?
                               9'(step_sub - 10'(csd_pkg::SUB_MASK_SIZE)) : step_sub[8:0];
                  hm_xor_ff <= (step_xor >= 10'(csd_pkg::XOR_MASK_SIZE)) ?
                               9'(step_xor - 10'(csd_pkg::XOR_MASK_SIZE)) : step_xor[8:0];
                  hi3_ff    <= (hi3_ff == 2'd2) ? 2'd0 : hi3_ff + 2'd1;
               end
            end
            kind_ff       <= csd_pkg::KIND_COLOUR;
            thread_out_ff <= '0;
            red_ff        <= '0;
            green_ff      <= '0;
            blue_ff       <= '0;
            dx_ff         <= '0;
            dy_ff         <= '0;
            order_out_ff  <= '0;
            bad_ff        <= 1'b0;
            if (hdr_ff < 7'(csd_pkg::HEADER_BYTES)) begin
               hdr_ff <= hdr_ff + 7'd1;
               if (hdr_ff < 7'(csd_pkg::COLOUR_BYTES)) begin
                  if (phase_ff == 2'd0) begin
                     held0_ff <= d;
                     phase_ff <= 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     held1_ff <= d;
                     phase_ff <= 2'd2;
                  end else begin
                     phase_ff      <= 2'd0;
                     thread_ff     <= thread_ff + 4'd1;
                     rsp_valid_ff  <= 1'b1;
                     thread_out_ff <= thread_ff;
                     red_ff        <= held0_ff;
                     green_ff      <= held1_ff;
                     blue_ff       <= d;
                  end
               end else if (hdr_ff >= 7'(csd_pkg::ORDER_START)) begin
                  order_ff[order_pos[3:0]] <= d;
               end
            end else if (phase_ff == 2'd0) begin
               held0_ff <= d;
               phase_ff <= 2'd1;
            end else if (phase_ff == 2'd1) begin
               held1_ff <= d;
               phase_ff <= 2'd2;
            end else begin
               phase_ff     <= 2'd0;
               rsp_valid_ff <= 1'b1;
               priority if (is_end) begin
                  done_ff <= 1'b1;
                  kind_ff <= csd_pkg::KIND_END;
               end else if (flags == 5'd0) begin
                  kind_ff <= csd_pkg::KIND_NORMAL;
                  dx_ff   <= held0_ff[5] ? 8'(-d) : d;
                  dy_ff   <= held0_ff[6] ? 8'(-held1_ff) : held1_ff;
               end else if ((flags & csd_pkg::CHANGE_MASK) != 5'd0) begin
                  kind_ff      <= csd_pkg::KIND_CHANGE;
                  order_out_ff <= order_ff[order_idx[3:0]];
                  bad_ff       <= cc_ff >= 5'(csd_pkg::ORDER_ENTRIES + 1);
                  cc_ff        <= (cc_ff == 5'd31) ? 5'd18 : cc_ff + 5'd1;
               end else begin
                  kind_ff <= csd_pkg::KIND_TRIM;
                  dx_ff   <= held0_ff[5] ? 8'(-d) : d;
                  dy_ff   <= held0_ff[6] ? 8'(-held1_ff) : held1_ff;
               end
            end
         end
      end
   end

endmodule
